// ===== rtl/rectangle_iou_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RECTANGLE_IOU_UNIT_MACROS_SVH
`define RECTANGLE_IOU_UNIT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define RIOU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rectangle_iou_unit: property violated");

// Expression must never be true outside reset.
`define RIOU_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("rectangle_iou_unit: forbidden condition seen");

`endif

// ===== rtl/riou_pkg.sv =====
package riou_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned ExtBits     = CoordBits;
  localparam int unsigned AreaBits    = 2 * ExtBits;
  localparam int unsigned UniBits     = AreaBits + 1;
  localparam int unsigned RemBits     = UniBits + 1;
  localparam int unsigned QuoBits     = FracBits + 1;
  localparam int unsigned FrontStages = 3;
  localparam int unsigned Latency     = FrontStages + QuoBits;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [ExtBits-1:0]          ext_t;
  typedef logic [AreaBits-1:0]         area_t;
  typedef logic [UniBits-1:0]          uni_t;
  typedef logic [RemBits-1:0]          rem_t;
  typedef logic [QuoBits-1:0]          quo_t;

  typedef struct packed {
    coord_t a_left;
    coord_t a_top;
    coord_t a_right;
    coord_t a_bottom;
    coord_t b_left;
    coord_t b_top;
    coord_t b_right;
    coord_t b_bottom;
  } box_pair_t;

  typedef struct packed {
    quo_t iou_ratio;
    logic union_zero;
  } iou_result_t;

  // One beat travelling down the divider chain.
  typedef struct packed {
    rem_t rem;
    uni_t divisor;
    quo_t quo;
    logic zero;
  } div_beat_t;

endpackage

// ===== rtl/rectangle_iou_unit.sv =====
// Channel   Direction  Handshake             Payload
// command   in         start / busy          boxes_i  (box_pair_t)
// result    out        done_o strobe         result_o (iou_result_t)
//
// One box pair is taken every cycle; busy stays low, so back-to-back starts are fine.
// Each result passes through three front stages (extents, products, union)
// and then one divider cell per quotient bit.
// Reset clears only the valid bits down the pipeline; payload registers are not reset.
// done_o is a one-cycle strobe and cannot be held off by the receiver.
module rectangle_iou_unit import riou_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  box_pair_t   boxes_i,
  output logic        done_o,
  output iou_result_t result_o
);

  logic      valid_c [QuoBits+1];
  div_beat_t beat_c  [QuoBits+1];

  riou_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .boxes_i (boxes_i),
    .valid_o (valid_c[0]),
    .beat_o  (beat_c[0])
  );

  for (genvar i = 0; i < QuoBits; i++) begin : g_cell
    riou_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .beat_i  (beat_c[i]),
      .valid_o (valid_c[i+1]),
      .beat_o  (beat_c[i+1])
    );
  end

  assign busy   = 1'b0;
  assign done_o = valid_c[QuoBits];

  // zero union: the quotient is meaningless, force the ratio to zero
  assign result_o.iou_ratio  = beat_c[QuoBits].zero ? '0 : beat_c[QuoBits].quo;
  assign result_o.union_zero = beat_c[QuoBits].zero;

endmodule

// ===== rtl/riou_front.sv =====
module riou_front import riou_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  box_pair_t boxes_i,
  output logic      valid_o,
  output div_beat_t beat_o
);

  logic [CoordBits:0] wa_diff, ha_diff, wb_diff, hb_diff, iw_diff, ih_diff;
  coord_t             ix_lo, ix_hi, iy_lo, iy_hi;
  ext_t               wa_d, ha_d, wb_d, hb_d, iw_d, ih_d;
  ext_t               wa_q, ha_q, wb_q, hb_q, iw_q, ih_q;
  area_t              area_a_q, area_b_q, inter_q;
  uni_t               uni_d;
  logic [FrontStages-1:0] valid_q;
  div_beat_t          beat_d, beat_q;

  function automatic ext_t abs_ext(logic [CoordBits:0] d);
    logic [CoordBits:0] m;
    m = d[CoordBits] ? (~d + 1'b1) : d;
    return m[ExtBits-1:0];
  endfunction

  // Stage 1: box extents and clamped overlap extents.
  assign wa_diff = {boxes_i.a_right[CoordBits-1], boxes_i.a_right}
                 - {boxes_i.a_left[CoordBits-1], boxes_i.a_left};
  assign ha_diff = {boxes_i.a_bottom[CoordBits-1], boxes_i.a_bottom}
                 - {boxes_i.a_top[CoordBits-1], boxes_i.a_top};
  assign wb_diff = {boxes_i.b_right[CoordBits-1], boxes_i.b_right}
                 - {boxes_i.b_left[CoordBits-1], boxes_i.b_left};
  assign hb_diff = {boxes_i.b_bottom[CoordBits-1], boxes_i.b_bottom}
                 - {boxes_i.b_top[CoordBits-1], boxes_i.b_top};

  assign ix_hi = (boxes_i.a_right < boxes_i.b_right) ? boxes_i.a_right : boxes_i.b_right;
  assign ix_lo = (boxes_i.a_left < boxes_i.b_left) ? boxes_i.b_left : boxes_i.a_left;
  assign iy_hi = (boxes_i.a_bottom < boxes_i.b_bottom) ? boxes_i.a_bottom : boxes_i.b_bottom;
  assign iy_lo = (boxes_i.a_top < boxes_i.b_top) ? boxes_i.b_top : boxes_i.a_top;

  assign iw_diff = {ix_hi[CoordBits-1], ix_hi} - {ix_lo[CoordBits-1], ix_lo};
  assign ih_diff = {iy_hi[CoordBits-1], iy_hi} - {iy_lo[CoordBits-1], iy_lo};

  always_comb begin
    wa_d = abs_ext(wa_diff);
    ha_d = abs_ext(ha_diff);
    wb_d = abs_ext(wb_diff);
    hb_d = abs_ext(hb_diff);
    // drop negative overlap
    iw_d = iw_diff[CoordBits] ? '0 : iw_diff[ExtBits-1:0];
    ih_d = ih_diff[CoordBits] ? '0 : ih_diff[ExtBits-1:0];
  end

  // Stage 3: union from the registered products.
  assign uni_d = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};

  always_comb begin
    beat_d.rem     = {{(RemBits-AreaBits){1'b0}}, inter_q};
    beat_d.divisor = uni_d;
    beat_d.quo     = '0;
    beat_d.zero    = (uni_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q     <= wa_d;
    ha_q     <= ha_d;
    wb_q     <= wb_d;
    hb_q     <= hb_d;
    iw_q     <= iw_d;
    ih_q     <= ih_d;
    area_a_q <= area_t'(wa_q) * area_t'(ha_q);
    area_b_q <= area_t'(wb_q) * area_t'(hb_q);
    inter_q  <= area_t'(iw_q) * area_t'(ih_q);
    beat_q   <= beat_d;
  end

  assign valid_o = valid_q[FrontStages-1];
  assign beat_o  = beat_q;

endmodule

// ===== rtl/riou_div_cell.sv =====
module riou_div_cell import riou_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  div_beat_t beat_i,
  output logic      valid_o,
  output div_beat_t beat_o
);

  rem_t      divisor_ext, trial, rem_next;
  logic      take;
  div_beat_t beat_d, beat_q;
  logic      valid_q;

  assign divisor_ext = {1'b0, beat_i.divisor};
  assign trial       = beat_i.rem - divisor_ext;
  assign take        = (beat_i.rem >= divisor_ext);
  assign rem_next    = take ? trial : beat_i.rem;

  // One restoring step: keep the difference if it fits, then shift for the next bit.
  always_comb begin
    beat_d         = beat_i;
    beat_d.rem     = {rem_next[RemBits-2:0], 1'b0};
    beat_d.quo     = {beat_i.quo[QuoBits-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/riou_checker.sv =====
`include "rectangle_iou_unit_macros.svh"

module riou_checker import riou_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input iou_result_t result_o
);

  `RIOU_NEVER(a_never_busy, clk_i, rst_ni, (busy))
  `RIOU_ASSERT(a_start_gives_done, clk_i, rst_ni, ((start && !busy) |-> ##Latency done_o))
  `RIOU_ASSERT(a_done_has_start, clk_i, rst_ni, (done_o |-> $past(start && !busy, Latency)))
  `RIOU_ASSERT(a_zero_union_ratio, clk_i, rst_ni, ((done_o && result_o.union_zero) |-> (result_o.iou_ratio == '0)))
  `RIOU_NEVER(a_ratio_above_one, clk_i, rst_ni, (done_o && (result_o.iou_ratio > (QuoBits'(1) << FracBits))))

endmodule

bind rectangle_iou_unit riou_checker u_riou_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
